// ----- design/fsc_pkg.sv -----
// Shared constants, codes and helper functions for the frustum sphere cull block.
`timescale 1ns / 1ps

package fsc_pkg;

   // Fixed-point format and plane count.
   localparam int FRAC_BITS  = 16;
   localparam int NUM_PLANES = 6;

   // Storage sizes and the widths that follow from them.
   localparam int MAT_DEPTH   = 16;
   localparam int PLANE_DEPTH = 4 * NUM_PLANES;
   localparam int MAT_AW      = $clog2(MAT_DEPTH);
   localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

   // Iterative units: square root of a 64-bit sum, and the normalizing divide.
   localparam int SQ_ITER   = 32;
   localparam int SQ_CNT_W  = $clog2(SQ_ITER);
   localparam int DIV_W     = 32 + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Dot product accumulator: three 64-bit products plus the shifted offset.
   localparam int ACC_W = 66;

   // Request codes carried in tuser.
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_EXTRACT = 2'd1;
   localparam logic [1:0] REQ_TEST    = 2'd2;

   // Failing plane code when no plane rejects the sphere.
   localparam logic [2:0] NO_FAIL   = 3'd6;
   localparam logic [2:0] LAST_PLANE = 3'(NUM_PLANES - 1);

   // Matrix row that pairs with row 3 for each plane: left, right, top, bottom, near, far.
   function automatic logic [1:0] plane_row(input logic [2:0] p);
      logic [1:0] r;
      case (p)
         3'd0, 3'd1: r = 2'd0;
         3'd2, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   // High when the plane adds the paired row, low when it subtracts it.
   function automatic logic plane_adds(input logic [2:0] p);
      logic a;
      case (p)
         3'd0, 3'd3, 3'd4: a = 1'b1;
         default:          a = 1'b0;
      endcase
      return a;
   endfunction

   // Clamp a 33-bit signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- design/frustum_sphere_cull.sv -----
// Top level: matrix and plane memories, plane extraction and sphere test sequencer.
// A matrix write is stored when accepted. A sphere test examines the planes in order
//   until one rejects it and then hands its verdict to the result register; ortho tests
//   skip the planes. Extraction runs per plane the matrix reads, the square steps, the
//   square root and the normalizing divides of the components, for all planes in turn.
// One item is in work at a time; the shared multiplier and memory read ports set the pace.
// Reset is synchronous and active high; it clears both memories through valid bits.
`timescale 1ns / 1ps

module frustum_sphere_cull
   import fsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // tdata: elem_col[1:0], elem_row[3:2], elem_value[35:4], center_x[67:36],
   //        center_y[99:68], center_z[131:100], sphere_radius[162:132], zero fill
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]   req_tuser,
   // tdata: visible[0], failing_plane[3:1], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_EX_RD   = 9'b000000010,
      S_EX_SQ   = 9'b000000100,
      S_EX_SQS  = 9'b000001000,
      S_EX_SQRT = 9'b000010000,
      S_EX_DIV  = 9'b000100000,
      S_EX_DIVW = 9'b001000000,
      S_CULL    = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Input field views.
   logic [1:0]         in_type;
   logic [1:0]         in_col, in_row;
   logic [31:0]        in_value;
   logic signed [31:0] in_cx, in_cy, in_cz;
   logic [30:0]        in_radius;
   logic               req_accept;

   assign in_type   = req_tuser;
   assign in_col    = req_tdata[1:0];
   assign in_row    = req_tdata[3:2];
   assign in_value  = req_tdata[35:4];
   assign in_cx     = req_tdata[67:36];
   assign in_cy     = req_tdata[99:68];
   assign in_cz     = req_tdata[131:100];
   assign in_radius = req_tdata[162:132];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Registers.
   logic                    ortho_ff, ortho_in;
   logic [2:0]              plane_ff, plane_in;
   logic [3:0]              step_ff, step_in;
   logic signed [31:0]      v_ff [4];
   logic signed [31:0]      v_in [4];
   logic signed [31:0]      base_ff, base_in;
   logic [63:0]             ss_ff, ss_in;
   logic [31:0]             len_ff, len_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]      cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [30:0]             r_ff, r_in;
   logic                    res_vis_ff, res_vis_in;
   logic [2:0]              res_fp_ff, res_fp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_vis_ff, rsp_vis_in;
   logic [2:0]              rsp_fp_ff, rsp_fp_in;
   logic [MAT_DEPTH-1:0]    mat_vld_ff, mat_vld_in;
   logic [PLANE_DEPTH-1:0]  pl_vld_ff, pl_vld_in;
   logic                    mrd_vld_ff, mrd_vld_in;
   logic                    prd_vld_ff, prd_vld_in;

   // Memory ports.
   logic                mat_we;
   logic [MAT_AW-1:0]   mat_waddr, mat_raddr;
   logic [31:0]         mat_q;
   logic                pl_we;
   logic [PLANE_AW-1:0] pl_waddr, pl_raddr;
   logic [31:0]         pl_wdata, pl_q;
   logic signed [31:0]  mdata, pdata;

   assign mat_we    = req_accept && (in_type == REQ_WRITE);
   assign mat_waddr = {in_col, in_row};

   fsc_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat_ram (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (in_value),
      .raddr (mat_raddr),
      .rdata (mat_q)
   );

   fsc_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_plane_ram (
      .clock (clock),
      .we    (pl_we),
      .waddr (pl_waddr),
      .wdata (pl_wdata),
      .raddr (pl_raddr),
      .rdata (pl_q)
   );

   // Entries never written since reset read as zero.
   assign mdata = mrd_vld_ff ? mat_q : '0;
   assign pdata = prd_vld_ff ? pl_q : '0;

   // Iterative units.
   logic             sqrt_start, sqrt_done;
   logic [31:0]      sqrt_root;
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_quot;

   fsc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (ss_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Normalizing divide operands and the saturated signed quotient.
   logic signed [31:0] comp;
   logic               comp_neg;
   logic [31:0]        comp_mag;
   logic signed [31:0] norm_val;

   always_comb begin
      comp     = v_ff[step_ff[1:0]];
      comp_neg = comp[31];
      comp_mag = comp_neg ? 32'(-comp) : comp;
      div_dividend = {comp_mag, {FRAC_BITS{1'b0}}};
      if (comp_neg) begin
         norm_val = (div_quot > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                       : 32'(-div_quot[31:0]);
      end else begin
         norm_val = (div_quot > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : div_quot[31:0];
      end
   end

   // Shared multiplier.
   logic signed [31:0] mult_a, mult_b;
   logic signed [63:0] mult_p;

   assign mult_p = mult_a * mult_b;

   // Scratch values for the sequencer.
   logic [2:0]              rd_idx;
   logic signed [32:0]      pair_sum;
   logic signed [32:0]      d_plus_r;
   logic signed [ACC_W-1:0] acc_sum;
   logic                    rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      ortho_in     = ortho_ff;
      plane_in     = plane_ff;
      step_in      = step_ff;
      v_in         = v_ff;
      base_in      = base_ff;
      ss_in        = ss_ff;
      len_in       = len_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      r_in         = r_ff;
      res_vis_in   = res_vis_ff;
      res_fp_in    = res_fp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_vis_in   = rsp_vis_ff;
      rsp_fp_in    = rsp_fp_ff;
      mat_vld_in   = mat_vld_ff;
      pl_vld_in    = pl_vld_ff;
      mat_raddr    = '0;
      pl_raddr     = '0;
      pl_we        = 1'b0;
      pl_waddr     = {plane_ff, step_ff[1:0]};
      pl_wdata     = comp;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      mult_a       = '0;
      mult_b       = '0;
      rd_idx       = step_ff[2:0] - 3'd1;
      pair_sum     = '0;
      d_plus_r     = '0;
      acc_sum      = acc_ff + ACC_W'(prod_ff);

      if (csr_valid && csr_ready) begin
         ortho_in = csr_data;
      end
      if (mat_we) begin
         mat_vld_in[mat_waddr] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               plane_in = '0;
               step_in  = '0;
               if (in_type == REQ_EXTRACT && !ortho_ff) begin
                  state_in = S_EX_RD;
               end else if (in_type == REQ_TEST) begin
                  cx_in = in_cx;
                  cy_in = in_cy;
                  cz_in = in_cz;
                  r_in  = in_radius;
                  if (ortho_ff) begin
                     res_vis_in = 1'b1;
                     res_fp_in  = NO_FAIL;
                     state_in   = S_RESP;
                  end else begin
                     state_in = S_CULL;
                  end
               end
            end
         end

         // Read row 3 and the paired row of each column; form the plane components.
         S_EX_RD: begin
            mat_raddr = step_ff[0] ? {step_ff[2:1], plane_row(plane_ff)}
                                   : {step_ff[2:1], 2'd3};
            if (step_ff != 4'd0) begin
               if (!rd_idx[0]) begin
                  base_in = mdata;
               end else begin
                  pair_sum = plane_adds(plane_ff) ? {base_ff[31], base_ff} + {mdata[31], mdata}
                                                  : {base_ff[31], base_ff} - {mdata[31], mdata};
                  v_in[rd_idx[2:1]] = sat33(pair_sum);
               end
            end
            if (step_ff == 4'd8) begin
               step_in  = '0;
               state_in = S_EX_SQ;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end

         // Sum of squares of the normal through the shared multiplier.
         S_EX_SQ: begin
            mult_a = v_ff[step_ff[1:0]];
            mult_b = v_ff[step_ff[1:0]];
            prod_in = mult_p;
            if (step_ff == 4'd1) begin
               ss_in = prod_ff;
            end else if (step_ff != 4'd0) begin
               ss_in = ss_ff + prod_ff;
            end
            if (step_ff == 4'd3) begin
               state_in = S_EX_SQS;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end

         S_EX_SQS: begin
            sqrt_start = 1'b1;
            state_in   = S_EX_SQRT;
         end

         S_EX_SQRT: begin
            if (sqrt_done) begin
               len_in   = sqrt_root;
               step_in  = '0;
               state_in = S_EX_DIV;
            end
         end

         // A zero-length normal stores the raw component; otherwise divide.
         S_EX_DIV: begin
            if (len_ff == '0) begin
               pl_we = 1'b1;
               pl_wdata = comp;
               pl_vld_in[pl_waddr] = 1'b1;
               if (step_ff[1:0] == 2'd3) begin
                  step_in = '0;
                  if (plane_ff == LAST_PLANE) begin
                     state_in = S_IDLE;
                  end else begin
                     plane_in = plane_ff + 3'd1;
                     state_in = S_EX_RD;
                  end
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = S_EX_DIVW;
            end
         end

         S_EX_DIVW: begin
            if (div_done) begin
               pl_we = 1'b1;
               pl_wdata = norm_val;
               pl_vld_in[pl_waddr] = 1'b1;
               if (step_ff[1:0] == 2'd3) begin
                  step_in = '0;
                  if (plane_ff == LAST_PLANE) begin
                     state_in = S_IDLE;
                  end else begin
                     plane_in = plane_ff + 3'd1;
                     state_in = S_EX_RD;
                  end
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_EX_DIV;
               end
            end
         end

         // Exact signed distance of the sphere per plane: read, multiply, accumulate.
         S_CULL: begin
            pl_raddr = {plane_ff, step_ff[1:0]};
            if (step_ff >= 4'd1 && step_ff <= 4'd4) begin
               case (rd_idx[1:0])
                  2'd0: begin
                     mult_a  = pdata;
                     mult_b  = cx_ff;
                     prod_in = mult_p;
                  end
                  2'd1: begin
                     mult_a  = pdata;
                     mult_b  = cy_ff;
                     prod_in = mult_p;
                  end
                  2'd2: begin
                     mult_a  = pdata;
                     mult_b  = cz_ff;
                     prod_in = mult_p;
                  end
                  default: begin
                     d_plus_r = {pdata[31], pdata} + {2'b00, r_ff};
                     prod_in  = {{31{d_plus_r[32]}}, d_plus_r} <<< FRAC_BITS;
                  end
               endcase
            end
            if (step_ff == 4'd2) begin
               acc_in = ACC_W'(prod_ff);
            end else if (step_ff == 4'd3 || step_ff == 4'd4) begin
               acc_in = acc_sum;
            end
            if (step_ff == 4'd5) begin
               step_in = '0;
               if (acc_sum[ACC_W-1]) begin
                  res_vis_in = 1'b0;
                  res_fp_in  = plane_ff;
                  state_in   = S_RESP;
               end else if (plane_ff == LAST_PLANE) begin
                  res_vis_in = 1'b1;
                  res_fp_in  = NO_FAIL;
                  state_in   = S_RESP;
               end else begin
                  plane_in = plane_ff + 3'd1;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in   = res_vis_ff;
               rsp_fp_in    = res_fp_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      mrd_vld_in = mat_vld_ff[mat_raddr];
      prd_vld_in = pl_vld_ff[pl_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ortho_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mat_vld_ff   <= '0;
         pl_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         ortho_ff     <= ortho_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_vld_ff   <= mat_vld_in;
         pl_vld_ff    <= pl_vld_in;
      end
      plane_ff   <= plane_in;
      step_ff    <= step_in;
      v_ff       <= v_in;
      base_ff    <= base_in;
      ss_ff      <= ss_in;
      len_ff     <= len_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      r_ff       <= r_in;
      res_vis_ff <= res_vis_in;
      res_fp_ff  <= res_fp_in;
      rsp_vis_ff <= rsp_vis_in;
      rsp_fp_ff  <= rsp_fp_in;
      mrd_vld_ff <= mrd_vld_in;
      prd_vld_ff <= prd_vld_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_fp_ff, rsp_vis_ff};

`ifndef SYNTHESIS
   // An orthographic sphere test goes straight to the result stage.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && in_type == REQ_TEST && ortho_ff |=> state_ff == S_RESP)
      else $error("ortho sphere test did not bypass the plane loop");

   // A visible result always names no failing plane, and a culled one names a real plane.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == NO_FAIL)))
      else $error("visible flag and failing plane disagree");

   // The plane memory is written only by extraction.
   assert property (@(posedge clock) disable iff (reset)
      pl_we |-> (state_ff == S_EX_DIV || state_ff == S_EX_DIVW))
      else $error("plane memory written outside extraction");

   // Divider results arrive only while the sequencer waits for them.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_EX_DIVW)
      else $error("divider finished while not awaited");

   // Square root results arrive only while the sequencer waits for them.
   assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == S_EX_SQRT)
      else $error("square root finished while not awaited");
`endif

endmodule

// ----- design/fsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/fsc_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module fsc_isqrt
   import fsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]         x_ff, x_in;
   logic [35:0]         rem_ff, rem_in;
   logic [31:0]         root_ff, root_in;
   logic [35:0]         rem_t;
   logic [35:0]         trial;
   logic                fits;

   // One digit of the square root recurrence.
   always_comb begin
      rem_t = {rem_ff[33:0], x_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      fits  = rem_t >= trial;
   end

   // Sequencing of the recurrence.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in    = {x_ff[61:0], 2'b00};
         rem_in  = fits ? rem_t - trial : rem_t;
         root_in = {root_ff[30:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(SQ_ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- design/fsc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fsc_div
   import fsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          dsr_ff, dsr_in;
   logic [32:0]          rem_t;
   logic [32:0]          rem_sub;
   logic                 fits;

   // Trial subtraction for the next quotient bit.
   always_comb begin
      rem_t   = {rem_ff, dvd_ff[DIV_W-1]};
      rem_sub = rem_t - {1'b0, dsr_ff};
      fits    = rem_t >= {1'b0, dsr_ff};
   end

   // The dividend register fills with quotient bits as it shifts out.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         rem_in = fits ? rem_sub[31:0] : rem_t[31:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ----- tb/tb_frustum_sphere_cull.sv -----
// Self-checking testbench for the frustum sphere cull block with its own plane model.
`timescale 1ns / 1ps

module tb_frustum_sphere_cull;
   import fsc_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_type;

   typedef struct {
      logic [1:0]         kind;
      logic [1:0]         col;
      logic [1:0]         row;
      logic signed [31:0] val;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [30:0]        rad;
   } cull_req_type;

   typedef struct {
      logic       visible;
      logic [2:0] plane;
   } cull_verdict_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   frustum_sphere_cull i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Model state: matrix, extracted planes and camera mode.
   logic signed [31:0] mdl_matrix [MAT_DEPTH];
   logic signed [31:0] mdl_planes [PLANE_DEPTH];
   logic               mdl_ortho = 1'b0;

   cull_req_type     pending_reqs[$];
   cull_verdict_type expected_verdicts[$];
   cull_req_type     cur_req;
   bit               req_taken = 0;
   idle_mode_type    idle_mode = IDLE_NONE;
   int               hold_cnt = 0;
   int               failures = 0;
   int               mismatches = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root64(input longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] scale_comp(input logic signed [31:0] comp,
                                                     input longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = comp < 0 ? longint'(-longint'(comp)) : longint'(comp);
      q = (mag << FRAC_BITS) / len;
      if (comp < 0) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return clamp32(-longint'(q));
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   // Form the six planes from row 3 and its partner row, then normalize them.
   task automatic extract_frustum();
      logic signed [31:0] v [4];
      longint unsigned    ss;
      longint unsigned    len;
      longint             base;
      longint             other;
      for (int p = 0; p < NUM_PLANES; p++) begin
         ss = 0;
         for (int j = 0; j < 4; j++) begin
            base  = mdl_matrix[j * 4 + 3];
            other = mdl_matrix[j * 4 + ((p < 2) ? 0 : (p < 4) ? 1 : 2)];
            v[j]  = clamp32((p == 0 || p == 3 || p == 4) ? base + other : base - other);
         end
         for (int j = 0; j < 3; j++) ss = ss + longint'(v[j]) * longint'(v[j]);
         len = root64(ss);
         for (int j = 0; j < 4; j++) begin
            mdl_planes[p * 4 + j] = (len == 0) ? v[j] : scale_comp(v[j], len);
         end
      end
   endtask

   // Apply one accepted transaction to the model and queue any verdict.
   task automatic apply_req(input cull_req_type r);
      cull_verdict_type    vd;
      logic signed [127:0] s;
      longint              pa;
      longint              pb;
      longint              pc;
      case (r.kind)
         REQ_WRITE: mdl_matrix[{r.col, r.row}] = r.val;
         REQ_EXTRACT: if (!mdl_ortho) extract_frustum();
         REQ_TEST: begin
            vd.visible = 1'b1;
            vd.plane   = NO_FAIL;
            if (!mdl_ortho) begin
               for (int p = NUM_PLANES - 1; p >= 0; p--) begin
                  pa = longint'(mdl_planes[p * 4 + 0]) * longint'(r.cx);
                  pb = longint'(mdl_planes[p * 4 + 1]) * longint'(r.cy);
                  pc = longint'(mdl_planes[p * 4 + 2]) * longint'(r.cz);
                  s = pa;
                  s = s + pb;
                  s = s + pc;
                  s = s + ((longint'(mdl_planes[p * 4 + 3]) + longint'({1'b0, r.rad}))
                           <<< FRAC_BITS);
                  if (s < 0) begin
                     vd.visible = 1'b0;
                     vd.plane   = 3'(p);
                  end
               end
            end
            expected_verdicts.push_back(vd);
         end
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] rand_word(input int wide_pct);
      if ($urandom_range(99) < wide_pct) return $urandom;
      return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
   endfunction

   // Mostly writes and sphere tests with moderate values, rare extracts and noise.
   function automatic cull_req_type rand_req();
      cull_req_type r;
      int           pick;
      pick   = $urandom_range(99);
      r.kind = pick < 40 ? REQ_WRITE : pick < 42 ? REQ_EXTRACT : pick < 97 ? REQ_TEST
                                                                            : REQ_UNUSED;
      r.col  = $urandom_range(3);
      r.row  = $urandom_range(3);
      r.val  = rand_word(20);
      r.cx   = rand_word(25);
      r.cy   = rand_word(25);
      r.cz   = rand_word(25);
      r.rad  = $urandom_range(99) < 25 ? 31'($urandom) : 31'($urandom_range(32'h0003_0000));
      return r;
   endfunction

   function automatic cull_req_type make_req(input logic [1:0] kind, input int col,
                                             input int row,
                                             input logic signed [31:0] val,
                                             input logic signed [31:0] c,
                                             input logic [30:0] rad);
      cull_req_type r;
      r = '{kind, 2'(col), 2'(row), val, c, -c, c, rad};
      return r;
   endfunction

   function automatic int idle_pct(input bit sender);
      case (idle_mode)
         IDLE_SEND: return sender ? 71 : 0;
         IDLE_RECV: return sender ? 0 : 71;
         IDLE_BOTH: return 17;
         default:   return 0;
      endcase
   endfunction

   // Request driver: a new transaction is offered once the last one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 0;
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct(1)) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= {5'd0, cur_req.rad, cur_req.cz, cur_req.cy, cur_req.cx,
                          cur_req.val, cur_req.row, cur_req.col};
            req_tuser  <= cur_req.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted on its own.
   always @(negedge clock) begin
      if (idle_mode == IDLE_HOLD && hold_cnt < 400) hold_cnt <= hold_cnt + 1;
   end

   // Result receiver stalls.
   always @(negedge clock) begin
      if (idle_mode == IDLE_HOLD && hold_cnt < 400) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && $urandom_range(99) >= idle_pct(0);
      end
   end

   // Monitor: update the model on accepted requests, check accepted verdicts.
   always @(posedge clock) begin
      cull_verdict_type vd;
      if (!reset && req_tvalid && req_tready) begin
         req_taken = 1;
         apply_req(cur_req);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            failures++;
            if (mismatches++ < 10) $display("unexpected verdict %h", rsp_tdata);
         end else begin
            vd = expected_verdicts.pop_front();
            if (rsp_tdata[0] !== vd.visible || rsp_tdata[3:1] !== vd.plane) begin
               failures++;
               if (mismatches++ < 10) begin
                  $display("verdict mismatch: expected visible %0d plane %0d, got %0d %0d",
                           vd.visible, vd.plane, rsp_tdata[0], rsp_tdata[3:1]);
               end
            end
         end
      end
   end

   // Write the camera mode register while the block is idle.
   task automatic write_mode(input logic mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      mdl_ortho = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every transaction to finish, then for a full extraction to settle.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_verdicts.size() > 0) begin
         @(posedge clock);
      end
      repeat (2000) @(posedge clock);
   endtask

   task automatic run_random(input int count, input idle_mode_type mode);
      idle_mode = mode;
      for (int i = 0; i < count; i++) pending_reqs.push_back(rand_req());
      drain();
   endtask

   initial begin
      for (int i = 0; i < MAT_DEPTH; i++) mdl_matrix[i] = '0;
      for (int i = 0; i < PLANE_DEPTH; i++) mdl_planes[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_mode(1'b0);

      // Directed: zero planes, saturating sums, zero normal, extreme spheres, noise.
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh8000_0000, 31'd0));
      pending_reqs.push_back(make_req(REQ_EXTRACT, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
      pending_reqs.push_back(make_req(REQ_WRITE, 0, 3, 32'sh7FFF_FFFF, 0, 0));
      pending_reqs.push_back(make_req(REQ_WRITE, 0, 0, 32'sh7FFF_FFFF, 0, 0));
      pending_reqs.push_back(make_req(REQ_WRITE, 1, 3, 32'sh8000_0000, 0, 0));
      pending_reqs.push_back(make_req(REQ_WRITE, 1, 1, 32'sh7FFF_FFFF, 0, 0));
      pending_reqs.push_back(make_req(REQ_WRITE, 2, 2, 32'sh0001_0000, 0, 0));
      pending_reqs.push_back(make_req(REQ_WRITE, 3, 3, 32'sh0001_0000, 0, 0));
      pending_reqs.push_back(make_req(REQ_WRITE, 3, 2, 32'shFFFF_0000, 0, 0));
      pending_reqs.push_back(make_req(REQ_EXTRACT, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh8000_0000, 31'd0));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh7FFF_FFFF, 31'd0));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh0000_0000, 31'h7FFF_FFFF));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh0001_0000, 31'd1));
      pending_reqs.push_back(make_req(REQ_UNUSED, 3, 3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                      31'h7FFF_FFFF));
      pending_reqs.push_back(make_req(REQ_WRITE, 0, 1, 32'sh0002_0000, 0, 0));
      pending_reqs.push_back(make_req(REQ_EXTRACT, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'shFFFF_0000, 31'h0000_8000));
      drain();

      run_random(400, IDLE_NONE);
      run_random(350, IDLE_SEND);

      // Orthographic camera: every test visible, extraction skipped.
      write_mode(1'b1);
      pending_reqs.push_back(make_req(REQ_EXTRACT, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0, 32'sh8000_0000, 31'd0));
      run_random(150, IDLE_RECV);
      write_mode(1'b0);

      // Back pressure: the receiver holds off while requests keep coming.
      run_random(80, IDLE_HOLD);
      run_random(300, IDLE_BOTH);
      run_random(270, IDLE_RECV);

      failures += expected_verdicts.size();
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
